// File: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic       OP_PUSH = 1'b0;
	localparam logic       OP_POP  = 1'b1;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic                         operation;
		logic signed [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] top_value;
		logic                         not_empty;
		logic [CNT_W-1:0]             entry_count;
		logic [1:0]                   error;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Array-based max-heap priority queue with push and pop of signed values.
//
//   channel   ports                 handshake
//   command   start, busy, req      word taken when start && !busy
//   result    done, rsp             word valid for the one cycle done is high
//
// A push starts at the next free slot and climbs the heap level by level; a
// pop moves the last entry to the root and sifts it down level by level. A
// refused word, an empty pop or a pop of the last entry goes straight to the
// finish state.
// The heap RAM has one write and one registered read port; one comparator is shared.
// Reset clears the state, entry count, error and done; the RAM is not cleared.
// The receiver cannot stall; done strobes in the same cycle that busy falls.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue
	import bmhq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_RD   = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_DN_LOAD = 4'd3;
	localparam logic [3:0] S_DN_RDL  = 4'd4;
	localparam logic [3:0] S_DN_RDR  = 4'd5;
	localparam logic [3:0] S_DN_SEL  = 4'd6;
	localparam logic [3:0] S_DN_CMP  = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]            state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [1:0]            err_q, err_d;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic [ADDR_W-1:0]     pos_q, pos_d;
	logic [ADDR_W-1:0]     cidx_q, cidx_d;
	logic [VALUE_BITS-1:0] mov_q, mov_d;
	logic [VALUE_BITS-1:0] cval_q, cval_d;
	logic [VALUE_BITS-1:0] root_q;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_q;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [VALUE_BITS-1:0] wr_data;

	logic [VALUE_BITS-1:0] cmp_a, cmp_b;
	logic                  cmp_gt;

	logic [ADDR_W-1:0]     parent;
	logic [CNT_W:0]        child, child_r, cnt_x;
	logic [CNT_W-1:0]      cnt_dec;
	logic                  accept;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign parent  = (pos_q - ADDR_W'(1)) >> 1;
	assign child   = (CNT_W+1)'({pos_q, 1'b1});
	assign child_r = child + (CNT_W+1)'(1);
	assign cnt_x   = {1'b0, cnt_q};
	assign cnt_dec = cnt_q - CNT_W'(1);

	// shared signed comparator
	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = mov_q;
				cmp_b = rd_q;
			end
			S_DN_SEL: begin
				cmp_a = rd_q;
				cmp_b = cval_q;
			end
			default: begin
				cmp_a = cval_q;
				cmp_b = mov_q;
			end
		endcase
	end
	assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		pos_d   = pos_q;
		cidx_d  = cidx_q;
		mov_d   = mov_q;
		cval_d  = cval_q;
		rd_en   = 1'b0;
		rd_addr = pos_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = mov_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					err_d = ERR_OK;
					if (req.operation == OP_PUSH) begin
						if (cnt_x >= (CNT_W+1)'(DEPTH)) begin
							err_d   = ERR_FULL;
							state_d = S_FIN;
						end else begin
							mov_d   = VALUE_BITS'(req.value);
							pos_d   = cnt_q[ADDR_W-1:0];
							cnt_d   = cnt_q + CNT_W'(1);
							state_d = S_UP_RD;
						end
					end else if (cnt_q == '0) begin
						err_d   = ERR_EMPTY;
						state_d = S_FIN;
					end else begin
						cnt_d = cnt_dec;
						pos_d = '0;
						if (cnt_dec == '0) begin
							state_d = S_FIN;
						end else begin
							rd_en   = 1'b1;
							rd_addr = cnt_dec[ADDR_W-1:0];
							state_d = S_DN_LOAD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (cmp_gt) begin
					wr_data = rd_q;
					pos_d   = parent;
					state_d = S_UP_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_LOAD: begin
				mov_d   = rd_q;
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (child >= cnt_x) begin
					wr_en   = 1'b1;
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = child[ADDR_W-1:0];
					state_d = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				cval_d = rd_q;
				cidx_d = child[ADDR_W-1:0];
				if (child_r < cnt_x) begin
					rd_en   = 1'b1;
					rd_addr = child_r[ADDR_W-1:0];
					state_d = S_DN_SEL;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_SEL: begin
				if (cmp_gt) begin
					cval_d = rd_q;
					cidx_d = cidx_q + ADDR_W'(1);
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (cmp_gt) begin
					wr_data = cval_q;
					pos_d   = cidx_q;
					state_d = S_DN_RDL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// heap RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		cidx_q <= cidx_d;
		mov_q  <= mov_d;
		cval_q <= cval_d;
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
		if (state_q == S_FIN) begin
			rsp_q.top_value   <= (cnt_q != '0) ? $signed(root_q) : '0;
			rsp_q.not_empty   <= (cnt_q != '0);
			rsp_q.entry_count <= cnt_q;
			rsp_q.error       <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			err_q   <= ERR_OK;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_checker
	import bmhq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t req,
	input wire logic done,
	input wire rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.not_empty == (rsp.entry_count != '0)))
		else $error("not_empty disagrees with entry_count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.not_empty |-> rsp.top_value == '0)
		else $error("empty queue reports nonzero top");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.entry_count <= CNT_W'(DEPTH) && rsp.error != 2'd3)
		else $error("count or error code out of range");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire

// File: verif/binary_max_heap_queue_test.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_test
// Self-checking bench for the max-heap queue. A short table of directed words
// (empty pops, extreme and equal values) is followed by random fill, drain and
// mixed episodes under several sender idling patterns. Each result is checked field
// by field against a directed row's fixed values or else an in-bench heap model.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bmhq_pkg::*;

	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam int RANDOM_WORDS = 450;
	localparam int PHASES       = 4;

	typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} episode_t;

	typedef struct {
		logic                         operation;
		logic signed [VALUE_BITS-1:0] value;
		bit                           has_fixed;
		rsp_t                         fixed;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	binary_max_heap_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// heap model
	logic signed [VALUE_BITS-1:0] heap_mem [DEPTH];
	int                           heap_fill = 0;
	int                           deepest_fill = 0;

	rsp_t     pending_rsp [$];
	bit       fixed_valid = 0;
	rsp_t     fixed_rsp;
	int       idle_pct = 0;
	int       stim_fill = 0;
	int       words_sent = 0;
	int       results_checked = 0;
	int       full_refusals = 0;
	int       empty_pops = 0;
	int       fail_count = 0;
	rsp_t     mon_exp;
	rsp_t     mon_pred;
	dir_row_t dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t heap_apply(req_t w);
		rsp_t                         r;
		int                           pos;
		int                           parent;
		int                           child;
		logic signed [VALUE_BITS-1:0] moving;
		r.error = ERR_OK;
		if (w.operation == OP_PUSH) begin
			if (heap_fill >= DEPTH) begin
				r.error = ERR_FULL;
			end else begin
				pos = heap_fill;
				moving = w.value;
				heap_fill++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!(moving > heap_mem[parent]))
						break;
					heap_mem[pos] = heap_mem[parent];
					pos = parent;
				end
				heap_mem[pos] = moving;
			end
		end else if (heap_fill == 0) begin
			r.error = ERR_EMPTY;
		end else begin
			heap_fill--;
			if (heap_fill > 0) begin
				moving = heap_mem[heap_fill];
				pos = 0;
				child = 1;
				while (child < heap_fill) begin
					if (child + 1 < heap_fill && heap_mem[child + 1] > heap_mem[child])
						child++;
					if (!(heap_mem[child] > moving))
						break;
					heap_mem[pos] = heap_mem[child];
					pos = child;
					child = pos * 2 + 1;
				end
				heap_mem[pos] = moving;
			end
		end
		r.top_value   = (heap_fill > 0) ? heap_mem[0] : '0;
		r.not_empty   = (heap_fill > 0);
		r.entry_count = CNT_W'(heap_fill);
		return r;
	endfunction

	task automatic report_diff(input string fname, input longint e, input longint a);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, e, a);
	endtask

	// result checker and model update on every accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 40)
						$display("%0t: result with no word outstanding, got top %0d count %0d err %0d",
							$time, rsp.top_value, rsp.entry_count, rsp.error);
				end else begin
					mon_exp = pending_rsp.pop_front();
					results_checked++;
					if (rsp.top_value !== mon_exp.top_value)
						report_diff("top_value", mon_exp.top_value, rsp.top_value);
					if (rsp.not_empty !== mon_exp.not_empty)
						report_diff("not_empty", mon_exp.not_empty, rsp.not_empty);
					if (rsp.entry_count !== mon_exp.entry_count)
						report_diff("entry_count", mon_exp.entry_count, rsp.entry_count);
					if (rsp.error !== mon_exp.error)
						report_diff("error", mon_exp.error, rsp.error);
				end
			end
			if (start && !busy) begin
				mon_pred = heap_apply(req);
				if (mon_pred.error == ERR_FULL)
					full_refusals++;
				if (mon_pred.error == ERR_EMPTY)
					empty_pops++;
				if (heap_fill > deepest_fill)
					deepest_fill = heap_fill;
				pending_rsp = {pending_rsp, (fixed_valid ? fixed_rsp : mon_pred)};
			end
		end
	end

	// offers one word, idling at random per cycle, until the block takes it
	task automatic send_word(input logic op, input logic signed [VALUE_BITS-1:0] v);
		bit   taken;
		req_t w;
		taken = 0;
		w.operation = op;
		w.value = v;
		while (!taken) begin
			if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				req <= req_t'({1'($urandom), VALUE_BITS'($urandom)});
			end else begin
				start <= 1'b1;
				req <= w;
			end
			@(posedge clk);
			taken = start && !busy;
		end
		words_sent++;
		if (op == OP_PUSH) begin
			if (stim_fill < DEPTH)
				stim_fill++;
		end else if (stim_fill > 0) begin
			stim_fill--;
		end
	endtask

	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return $urandom_range(6) - 3;
			default: return $urandom;
		endcase
	endfunction

	function automatic dir_row_t mk_row(input logic op, input logic signed [VALUE_BITS-1:0] v,
			input bit fixed, input logic signed [VALUE_BITS-1:0] top, input logic ne,
			input int cnt, input logic [1:0] err);
		dir_row_t r;
		r.operation         = op;
		r.value             = v;
		r.has_fixed         = fixed;
		r.fixed.top_value   = top;
		r.fixed.not_empty   = ne;
		r.fixed.entry_count = CNT_W'(cnt);
		r.fixed.error       = err;
		return r;
	endfunction

	function automatic void add_row(input dir_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	initial begin
		int       ph;
		int       k;
		int       len;
		int       phase_start;
		episode_t kind;
		int       idle_plan [PHASES];
		idle_plan = '{0, 59, 0, 23};
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;

		add_row(mk_row(OP_POP,  0,       1, 0,       0, 0, ERR_EMPTY));
		add_row(mk_row(OP_PUSH, VAL_MIN, 1, VAL_MIN, 1, 1, ERR_OK));
		add_row(mk_row(OP_PUSH, VAL_MAX, 1, VAL_MAX, 1, 2, ERR_OK));
		add_row(mk_row(OP_PUSH, 0,       1, VAL_MAX, 1, 3, ERR_OK));
		add_row(mk_row(OP_PUSH, -1,      1, VAL_MAX, 1, 4, ERR_OK));
		add_row(mk_row(OP_PUSH, VAL_MAX, 1, VAL_MAX, 1, 5, ERR_OK));
		add_row(mk_row(OP_PUSH, 32'h5555_5555, 0, 0, 0, 0, ERR_OK));
		add_row(mk_row(OP_PUSH, 32'haaaa_aaaa, 0, 0, 0, 0, ERR_OK));
		add_row(mk_row(OP_POP,  0,       1, VAL_MAX, 1, 6, ERR_OK));
		add_row(mk_row(OP_POP,  0,       0, 0,       0, 0, ERR_OK));
		// equal values
		for (k = 0; k < 3; k++)
			add_row(mk_row(OP_PUSH, 7, 0, 0, 0, 0, ERR_OK));
		for (k = 0; k < 7; k++)
			add_row(mk_row(OP_POP, 0, 0, 0, 0, 0, ERR_OK));
		add_row(mk_row(OP_POP,  0,       1, 0,       0, 0, ERR_OK));
		add_row(mk_row(OP_POP,  0,       1, 0,       0, 0, ERR_EMPTY));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// expected rows change at clock edges without racing the checker
		foreach (dir_rows[i]) begin
			fixed_valid <= dir_rows[i].has_fixed;
			fixed_rsp   <= dir_rows[i].fixed;
			send_word(dir_rows[i].operation, dir_rows[i].value);
		end
		fixed_valid <= 1'b0;

		for (ph = 0; ph < PHASES; ph++) begin
			idle_pct = idle_plan[ph];
			phase_start = words_sent;
			k = 0;
			while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
				if (k == 0 && ph < 3)
					kind = (ph == 1) ? EP_DRAIN : EP_FILL;
				else
					kind = episode_t'($urandom_range(2));
				k++;
				case (kind)
					EP_FILL: begin
						while (stim_fill < DEPTH)
							send_word(OP_PUSH, pick_value());
						repeat ($urandom_range(1, 3)) send_word(OP_PUSH, pick_value());
					end
					EP_DRAIN: begin
						while (stim_fill > 0)
							send_word(OP_POP, pick_value());
						repeat ($urandom_range(1, 3)) send_word(OP_POP, pick_value());
					end
					default: begin
						len = $urandom_range(8, 30);
						repeat (len)
							send_word(($urandom_range(99) < 55) ? OP_PUSH : OP_POP, pick_value());
					end
				endcase
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("tb: %0d words sent, %0d results checked, deepest fill %0d of %0d",
			words_sent, results_checked, deepest_fill, DEPTH);
		$display("tb: %0d pushes refused on full, %0d pops on empty", full_refusals, empty_pops);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: timeout with %0d results outstanding", pending_rsp.size());
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
